/* rtl/assert_macros.svh */
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, quiet while reset is held
`define GCFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// concurrent check that also runs during reset
`define GCFP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/gcfp_pkg.sv */
// shared types, constants and helpers for the capture fate predictor
package gcfp_pkg;

  localparam int unsigned DEF_ATTRACTORS = 8;
  localparam int unsigned DEF_MAX_STEPS  = 10000;
  localparam int unsigned DEF_FRAC_BITS  = 16;

  localparam int unsigned POS_W      = 32;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DRAG_W     = 17;
  localparam int unsigned DRAG_FRAC  = 16;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned WIDE_W     = 64;
  localparam int unsigned SUM_W      = 66;
  localparam int unsigned ITER_W     = 7;

  localparam logic [ITER_W-1:0] MUL_ITERS  = ITER_W'(32);
  localparam logic [ITER_W-1:0] DIV_ITERS  = ITER_W'(64);
  localparam logic [ITER_W-1:0] SQRT_ITERS = ITER_W'(32);

  localparam logic signed [SUM_W-1:0] CLAMP_HI = 66'sh0_7FFF_FFFF;
  localparam logic signed [SUM_W-1:0] CLAMP_LO = -66'sh0_8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK      = 3'd0,
    REG_CAPTURE   = 3'd1,
    REG_DRAG      = 3'd2,
    REG_SOFTENING = 3'd3,
    REG_FORCE     = 3'd4,
    REG_COUNT     = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    UOP_MUL  = 2'd0,
    UOP_DIV  = 2'd1,
    UOP_SQRT = 2'd2
  } unit_op_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_WRITE,
    OP_V2_CLR,
    OP_MUL_VSQ,
    OP_ACC_V2,
    OP_READ,
    OP_DC,
    OP_MUL_DSQ,
    OP_ACC_S4,
    OP_DIV_MAG,
    OP_SET_MAG,
    OP_MUL_F,
    OP_SET_F,
    OP_SQRT,
    OP_SET_LEN,
    OP_MUL_DF,
    OP_DIV_Q,
    OP_UPD_V,
    OP_MUL_DRAG,
    OP_SET_DRAG,
    OP_MUL_TICK,
    OP_UPD_P,
    OP_RES_HIT,
    OP_RES_MISS
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic capture;
  } dp_status_t;

  function automatic logic signed [POS_W-1:0] clamp32(input logic signed [SUM_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > CLAMP_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < CLAMP_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  // magnitude with a sign put back, widened for saturating sums
  function automatic logic signed [SUM_W-1:0] signed_wide(input logic neg,
                                                          input logic [WIDE_W-1:0] m);
    logic signed [SUM_W-1:0] t;
    t = $signed({2'b00, m});
    return neg ? -t : t;
  endfunction

endpackage

/* rtl/gravity_capture_fate_predictor.sv */
// a query runs at most MAX_STEPS steps over the n attractors in use and stops
//   early when a capture ends the run; a write request is taken while idle
// one request at a time; every multiply, divide and root goes through one
//   shared bit-serial unit
// reset: synchronous, restores the register defaults and idles the controller;
//   the attractor table is not cleared
module gravity_capture_fate_predictor import gcfp_pkg::*; #(
  parameter int unsigned ATTRACTORS = DEF_ATTRACTORS,
  parameter int unsigned MAX_STEPS  = DEF_MAX_STEPS,
  parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    req_type,
  input  logic [SLOT_W-1:0]       slot,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [COLOR_W-1:0]      entry_color,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [COLOR_W-1:0]      fate_color,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned AW = (ATTRACTORS > 1) ? $clog2(ATTRACTORS) : 1;
  localparam int unsigned IW = $clog2(ATTRACTORS + 1);

  dp_cmd_t       cmd;
  dp_status_t    status;
  logic [AW-1:0] rd_addr;
  logic [IW-1:0] n_attr;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  gcfp_ctrl #(
    .ATTRACTORS (ATTRACTORS),
    .MAX_STEPS  (MAX_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .status    (status),
    .n_attr    (n_attr)
  );

  gcfp_dp #(
    .ATTRACTORS (ATTRACTORS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .slot        (slot),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .entry_color (entry_color),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .status      (status),
    .n_attr      (n_attr),
    .fate_color  (fate_color)
  );

endmodule

/* rtl/gcfp_unit.sv */
// shared bit-serial multiply, restoring divide and integer square root
module gcfp_unit import gcfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  unit_op_t          op,
  input  logic [WIDE_W-1:0] a,
  input  logic [WIDE_W-1:0] b,
  output logic              busy,
  output logic [WIDE_W-1:0] res
);

  logic [ITER_W-1:0] cnt;
  logic [ITER_W-1:0] iters;
  unit_op_t          op_q;
  logic [WIDE_W-1:0] acc;
  logic [WIDE_W-1:0] opa;
  logic [WIDE_W-1:0] opb;
  logic [WIDE_W:0]   rem;

  logic [WIDE_W-1:0] mul_acc;
  logic [WIDE_W:0]   div_trial;
  logic              div_ge;
  logic [WIDE_W:0]   sq_trial;
  logic [WIDE_W:0]   sq_cmp;
  logic              sq_ge;

  always_comb begin
    case (op)
      UOP_DIV:  iters = DIV_ITERS;
      UOP_SQRT: iters = SQRT_ITERS;
      default:  iters = MUL_ITERS;
    endcase
  end

  assign mul_acc   = opb[0] ? acc + opa : acc;
  assign div_trial = {rem[WIDE_W-1:0], opa[WIDE_W-1]};
  assign div_ge    = div_trial >= {1'b0, opb};
  // two radicand bits enter per iteration
  assign sq_trial  = {rem[WIDE_W-2:0], opa[WIDE_W-1:WIDE_W-2]};
  assign sq_cmp    = {acc[WIDE_W-2:0], 2'b01};
  assign sq_ge     = sq_trial >= sq_cmp;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= iters;
    end else if (busy) begin
      cnt <= cnt - ITER_W'(1);
      if (cnt == ITER_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_q <= op;
      acc  <= '0;
      opa  <= a;
      opb  <= b;
      rem  <= '0;
    end else if (busy) begin
      case (op_q)
        UOP_MUL: begin
          acc <= mul_acc;
          opa <= opa << 1;
          opb <= opb >> 1;
        end
        UOP_DIV: begin
          if (div_ge) begin
            rem <= div_trial - {1'b0, opb};
            acc <= {acc[WIDE_W-2:0], 1'b1};
          end else begin
            rem <= div_trial;
            acc <= {acc[WIDE_W-2:0], 1'b0};
          end
          opa <= opa << 1;
        end
        UOP_SQRT: begin
          if (sq_ge) begin
            rem <= sq_trial - sq_cmp;
            acc <= {acc[WIDE_W-2:0], 1'b1};
          end else begin
            rem <= sq_trial;
            acc <= {acc[WIDE_W-2:0], 1'b0};
          end
          opa <= opa << 2;
        end
        default: begin
        end
      endcase
    end
  end

  assign res = acc;

endmodule

/* rtl/gcfp_dp.sv */
// datapath: configuration, attractor table, probe state and arithmetic
module gcfp_dp import gcfp_pkg::*; #(
  parameter  int unsigned ATTRACTORS = DEF_ATTRACTORS,
  parameter  int unsigned FRAC_BITS  = DEF_FRAC_BITS,
  localparam int unsigned AW = (ATTRACTORS > 1) ? $clog2(ATTRACTORS) : 1,
  localparam int unsigned IW = $clog2(ATTRACTORS + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [SLOT_W-1:0]       slot,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [COLOR_W-1:0]      entry_color,
  input  dp_cmd_t                 cmd,
  input  logic [AW-1:0]           rd_addr,
  output dp_status_t              status,
  output logic [IW-1:0]           n_attr,
  output logic [COLOR_W-1:0]      fate_color
);

  logic [31:0]        tick_length;
  logic [31:0]        capture_radius_sq;
  logic [DRAG_W-1:0]  drag_factor;
  logic [31:0]        softening;
  logic [31:0]        force_constant;
  logic [COUNT_W-1:0] attractor_count;

  logic signed [POS_W-1:0] mem_x [ATTRACTORS];
  logic signed [POS_W-1:0] mem_y [ATTRACTORS];
  logic signed [POS_W-1:0] mem_z [ATTRACTORS];
  logic [COLOR_W-1:0]      mem_c [ATTRACTORS];
  logic signed [POS_W-1:0] rd_x;
  logic signed [POS_W-1:0] rd_y;
  logic signed [POS_W-1:0] rd_z;
  logic [COLOR_W-1:0]      rd_c;
  logic [AW-1:0]           wr_addr;

  logic signed [POS_W-1:0] p [3];
  logic signed [POS_W-1:0] v [3];
  logic signed [POS_W:0]   dc [3];
  logic [WIDE_W-1:0]       s4;
  logic [WIDE_W-1:0]       v2;
  logic [31:0]             mag;
  logic [30:0]             f;
  logic [33:0]             len;

  logic signed [POS_W-1:0] v_sel;
  logic signed [POS_W-1:0] p_sel;
  logic signed [POS_W:0]   dc_sel;
  logic [POS_W-1:0]        v_mag;
  logic [POS_W:0]          dc_neg;
  logic [POS_W-1:0]        dc_mag;
  logic [WIDE_W-1:0]       d2;
  logic [WIDE_W-1:0]       res_frac;

  logic              u_start;
  unit_op_t          u_op;
  logic [WIDE_W-1:0] u_a;
  logic [WIDE_W-1:0] u_b;
  logic              u_busy;
  logic [WIDE_W-1:0] u_res;

  logic signed [POS_W-1:0] v_upd;
  logic signed [POS_W-1:0] v_drag;
  logic signed [POS_W-1:0] p_upd;

  gcfp_unit u_unit (
    .clk   (clk),
    .rst   (rst),
    .start (u_start),
    .op    (u_op),
    .a     (u_a),
    .b     (u_b),
    .busy  (u_busy),
    .res   (u_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_length       <= 32'd65536;
      capture_radius_sq <= 32'd0;
      drag_factor       <= DRAG_W'(65536);
      softening         <= 32'd655;
      force_constant    <= 32'd66;
      attractor_count   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TICK:      tick_length       <= cfg_data;
        REG_CAPTURE:   capture_radius_sq <= cfg_data;
        REG_DRAG:      drag_factor       <= cfg_data[DRAG_W-1:0];
        REG_SOFTENING: softening         <= cfg_data;
        REG_FORCE:     force_constant    <= cfg_data;
        REG_COUNT:     attractor_count   <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign n_attr = (int'(attractor_count) > int'(ATTRACTORS)) ? IW'(ATTRACTORS)
                                                             : IW'(attractor_count);

  assign wr_addr = AW'(slot);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE && int'(slot) < int'(ATTRACTORS)) begin
      mem_x[wr_addr] <= pos_x;
      mem_y[wr_addr] <= pos_y;
      mem_z[wr_addr] <= pos_z;
      mem_c[wr_addr] <= entry_color;
    end
    if (cmd.op == OP_READ) begin
      rd_x <= mem_x[rd_addr];
      rd_y <= mem_y[rd_addr];
      rd_z <= mem_z[rd_addr];
      rd_c <= mem_c[rd_addr];
    end
  end

  always_comb begin
    case (cmd.axis)
      2'd0: begin
        v_sel  = v[0];
        p_sel  = p[0];
        dc_sel = dc[0];
      end
      2'd1: begin
        v_sel  = v[1];
        p_sel  = p[1];
        dc_sel = dc[1];
      end
      default: begin
        v_sel  = v[2];
        p_sel  = p[2];
        dc_sel = dc[2];
      end
    endcase
  end

  assign v_mag    = v_sel[POS_W-1] ? (~v_sel + 32'd1) : v_sel;
  assign dc_neg   = ~dc_sel + 33'd1;
  assign dc_mag   = dc_sel[POS_W] ? dc_neg[POS_W-1:0] : dc_sel[POS_W-1:0];
  assign d2       = s4 >> (FRAC_BITS - 2);
  assign res_frac = u_res >> FRAC_BITS;

  assign status.busy    = u_busy;
  assign status.capture = (d2 < {32'd0, capture_radius_sq}) && (v2 < {32'd0, force_constant});

  always_comb begin
    u_start = 1'b0;
    u_op    = UOP_MUL;
    u_a     = '0;
    u_b     = '0;
    case (cmd.op)
      OP_MUL_VSQ: begin
        u_start = 1'b1;
        u_a     = WIDE_W'(v_mag);
        u_b     = WIDE_W'(v_mag);
      end
      OP_MUL_DSQ: begin
        u_start = 1'b1;
        u_a     = WIDE_W'(dc_mag);
        u_b     = WIDE_W'(dc_mag);
      end
      OP_DIV_MAG: begin
        u_start = 1'b1;
        u_op    = UOP_DIV;
        u_a     = WIDE_W'(force_constant) << FRAC_BITS;
        u_b     = WIDE_W'(softening) + d2;
      end
      OP_MUL_F: begin
        u_start = 1'b1;
        u_a     = WIDE_W'(tick_length);
        u_b     = WIDE_W'(mag);
      end
      OP_SQRT: begin
        u_start = 1'b1;
        u_op    = UOP_SQRT;
        u_a     = s4;
      end
      OP_MUL_DF: begin
        u_start = 1'b1;
        u_a     = WIDE_W'(dc_mag);
        u_b     = WIDE_W'(f);
      end
      OP_DIV_Q: begin
        u_start = 1'b1;
        u_op    = UOP_DIV;
        u_a     = u_res;
        u_b     = WIDE_W'(len);
      end
      OP_MUL_DRAG: begin
        u_start = 1'b1;
        u_a     = WIDE_W'(v_mag);
        u_b     = WIDE_W'(drag_factor);
      end
      OP_MUL_TICK: begin
        u_start = 1'b1;
        u_a     = WIDE_W'(v_mag);
        u_b     = WIDE_W'(tick_length);
      end
      default: begin
      end
    endcase
  end

  assign v_upd  = clamp32($signed({{34{v_sel[POS_W-1]}}, v_sel})
                          + signed_wide(dc_sel[POS_W], u_res));
  assign v_drag = clamp32(signed_wide(v_sel[POS_W-1], u_res >> DRAG_FRAC));
  assign p_upd  = clamp32($signed({{34{p_sel[POS_W-1]}}, p_sel})
                          + signed_wide(v_sel[POS_W-1], res_frac));

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        p[0] <= pos_x;
        p[1] <= pos_y;
        p[2] <= pos_z;
        for (int k = 0; k < 3; k++) begin
          v[k] <= '0;
        end
      end
      OP_V2_CLR: v2 <= '0;
      OP_ACC_V2: v2 <= v2 + res_frac;
      OP_DC: begin
        dc[0] <= {rd_x[POS_W-1], rd_x} - {p[0][POS_W-1], p[0]};
        dc[1] <= {rd_y[POS_W-1], rd_y} - {p[1][POS_W-1], p[1]};
        dc[2] <= {rd_z[POS_W-1], rd_z} - {p[2][POS_W-1], p[2]};
        s4    <= '0;
      end
      OP_ACC_S4: s4 <= s4 + (u_res >> 2);
      OP_SET_MAG: mag <= (u_res > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : u_res[31:0];
      OP_SET_F: f <= (res_frac > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : res_frac[30:0];
      // a zero root leaves a divisor of one
      OP_SET_LEN: len <= (u_res[32:0] == 33'd0) ? 34'd1 : {u_res[32:0], 1'b0};
      OP_UPD_V: begin
        for (int k = 0; k < 3; k++) begin
          if (cmd.axis == 2'(k)) v[k] <= v_upd;
        end
      end
      OP_SET_DRAG: begin
        for (int k = 0; k < 3; k++) begin
          if (cmd.axis == 2'(k)) v[k] <= v_drag;
        end
      end
      OP_UPD_P: begin
        for (int k = 0; k < 3; k++) begin
          if (cmd.axis == 2'(k)) p[k] <= p_upd;
        end
      end
      OP_RES_HIT:  fate_color <= rd_c;
      OP_RES_MISS: fate_color <= '0;
      default: begin
      end
    endcase
  end

endmodule

/* rtl/gcfp_ctrl.sv */
// controller: request handshake, step and attractor sequencing
module gcfp_ctrl import gcfp_pkg::*; #(
  parameter  int unsigned ATTRACTORS = DEF_ATTRACTORS,
  parameter  int unsigned MAX_STEPS  = DEF_MAX_STEPS,
  localparam int unsigned AW = (ATTRACTORS > 1) ? $clog2(ATTRACTORS) : 1,
  localparam int unsigned IW = $clog2(ATTRACTORS + 1),
  localparam int unsigned SW = $clog2(MAX_STEPS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          req_type,
  output logic          out_valid,
  input  logic          out_ready,
  output dp_cmd_t       cmd,
  output logic [AW-1:0] rd_addr,
  input  dp_status_t    status,
  input  logic [IW-1:0] n_attr
);

  typedef enum logic [23:0] {
    S_IDLE = 24'h000001,
    S_STEP = 24'h000002,
    S_VSQ  = 24'h000004,
    S_VACC = 24'h000008,
    S_RD   = 24'h000010,
    S_DC   = 24'h000020,
    S_DSQ  = 24'h000040,
    S_SACC = 24'h000080,
    S_CHK  = 24'h000100,
    S_MAG  = 24'h000200,
    S_FMUL = 24'h000400,
    S_FSET = 24'h000800,
    S_SQ   = 24'h001000,
    S_LEN  = 24'h002000,
    S_DF   = 24'h004000,
    S_DQ   = 24'h008000,
    S_UV   = 24'h010000,
    S_DRAG = 24'h020000,
    S_DSET = 24'h040000,
    S_TK   = 24'h080000,
    S_PUPD = 24'h100000,
    S_HIT  = 24'h200000,
    S_MISS = 24'h400000,
    S_WAIT = 24'h800000
  } state_t;

  state_t        state, state_next;
  state_t        ret, ret_next;
  logic [1:0]    axis, axis_next;
  logic [IW-1:0] idx, idx_next;
  logic [SW-1:0] step, step_next;
  logic          out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign rd_addr  = idx[AW-1:0];

  always_comb begin
    state_next = state;
    ret_next   = ret;
    axis_next  = axis;
    idx_next   = idx;
    step_next  = step;
    cmd.op     = OP_NONE;
    cmd.axis   = axis;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (req_type) begin
            cmd.op     = OP_LOAD;
            step_next  = '0;
            state_next = S_STEP;
          end else begin
            cmd.op = OP_WRITE;
          end
        end
      end
      S_STEP: begin
        cmd.op     = OP_V2_CLR;
        axis_next  = 2'd0;
        idx_next   = '0;
        state_next = S_VSQ;
      end
      S_VSQ: begin
        cmd.op     = OP_MUL_VSQ;
        ret_next   = S_VACC;
        state_next = S_WAIT;
      end
      S_VACC: begin
        cmd.op = OP_ACC_V2;
        if (axis == 2'd2) begin
          axis_next  = 2'd0;
          state_next = (n_attr == '0) ? S_DRAG : S_RD;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = S_VSQ;
        end
      end
      S_RD: begin
        cmd.op     = OP_READ;
        state_next = S_DC;
      end
      S_DC: begin
        cmd.op     = OP_DC;
        axis_next  = 2'd0;
        state_next = S_DSQ;
      end
      S_DSQ: begin
        cmd.op     = OP_MUL_DSQ;
        ret_next   = S_SACC;
        state_next = S_WAIT;
      end
      S_SACC: begin
        cmd.op = OP_ACC_S4;
        if (axis == 2'd2) begin
          axis_next  = 2'd0;
          state_next = S_CHK;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = S_DSQ;
        end
      end
      S_CHK: begin
        if (status.capture) begin
          state_next = S_HIT;
        end else begin
          cmd.op     = OP_DIV_MAG;
          ret_next   = S_MAG;
          state_next = S_WAIT;
        end
      end
      S_MAG: begin
        cmd.op     = OP_SET_MAG;
        state_next = S_FMUL;
      end
      S_FMUL: begin
        cmd.op     = OP_MUL_F;
        ret_next   = S_FSET;
        state_next = S_WAIT;
      end
      S_FSET: begin
        cmd.op     = OP_SET_F;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.op     = OP_SQRT;
        ret_next   = S_LEN;
        state_next = S_WAIT;
      end
      S_LEN: begin
        cmd.op     = OP_SET_LEN;
        axis_next  = 2'd0;
        state_next = S_DF;
      end
      S_DF: begin
        cmd.op     = OP_MUL_DF;
        ret_next   = S_DQ;
        state_next = S_WAIT;
      end
      S_DQ: begin
        cmd.op     = OP_DIV_Q;
        ret_next   = S_UV;
        state_next = S_WAIT;
      end
      S_UV: begin
        cmd.op = OP_UPD_V;
        if (axis == 2'd2) begin
          axis_next = 2'd0;
          if (idx + IW'(1) == n_attr) begin
            state_next = S_DRAG;
          end else begin
            idx_next   = idx + IW'(1);
            state_next = S_RD;
          end
        end else begin
          axis_next  = axis + 2'd1;
          state_next = S_DF;
        end
      end
      S_DRAG: begin
        cmd.op     = OP_MUL_DRAG;
        ret_next   = S_DSET;
        state_next = S_WAIT;
      end
      S_DSET: begin
        cmd.op     = OP_SET_DRAG;
        state_next = S_TK;
      end
      S_TK: begin
        cmd.op     = OP_MUL_TICK;
        ret_next   = S_PUPD;
        state_next = S_WAIT;
      end
      S_PUPD: begin
        cmd.op = OP_UPD_P;
        if (axis == 2'd2) begin
          axis_next = 2'd0;
          if (step == SW'(MAX_STEPS - 1)) begin
            state_next = S_MISS;
          end else begin
            step_next  = step + SW'(1);
            state_next = S_STEP;
          end
        end else begin
          axis_next  = axis + 2'd1;
          state_next = S_DRAG;
        end
      end
      S_HIT: begin
        if (out_free) begin
          cmd.op     = OP_RES_HIT;
          state_next = S_IDLE;
        end
      end
      S_MISS: begin
        if (out_free) begin
          cmd.op     = OP_RES_MISS;
          state_next = S_IDLE;
        end
      end
      S_WAIT: begin
        if (!status.busy) state_next = ret;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      axis      <= 2'd0;
      idx       <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      axis  <= axis_next;
      idx   <= idx_next;
      step  <= step_next;
      if ((state == S_HIT || state == S_MISS) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/gcfp_checker.sv */
// port-level checks for the capture fate predictor, bound to the top level
`include "assert_macros.svh"

module gcfp_checker import gcfp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               req_type,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COLOR_W-1:0] fate_color
);

  // an accepted query takes the block out of the idle state
  `GCFP_ASSERT(a_query_busy, in_valid && in_ready && req_type |=> !in_ready, "query request did not start work")

  // a table write completes at once
  `GCFP_ASSERT(a_write_quick, in_valid && in_ready && !req_type |=> in_ready, "write request stalled the block")

  `GCFP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(fate_color), "result dropped or changed while stalled")

  // a result only appears at the end of a busy period
  `GCFP_ASSERT(a_result_from_busy, $rose(out_valid) |-> !$past(in_ready), "result appeared while idle")

  `GCFP_ASSERT_ALWAYS(a_rst_clear, rst |=> !out_valid && in_ready, "reset did not clear the block")

endmodule

bind gravity_capture_fate_predictor gcfp_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .req_type   (req_type),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .fate_color (fate_color)
);

/* bench/tb_gravity_capture_fate_predictor.sv */
// testbench for the gravity capture fate predictor: directed and random requests, scoreboard
`timescale 1ns / 1ps

module tb_gravity_capture_fate_predictor;
  import gcfp_pkg::*;

  typedef longint unsigned u64_t;

  localparam int unsigned ATT        = DEF_ATTRACTORS;
  localparam int unsigned STEP_LIMIT = 200;     // shortened run keeps misses affordable
  localparam int unsigned STEP_GUARD = 8;       // random queries must capture this fast
  localparam longint      CYCLE_CAP  = 20000000;
  localparam logic signed [POS_W-1:0] PMAX = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] PMIN = 32'sh8000_0000;

  logic clk, rst;
  logic in_valid, in_ready, req_type;
  logic [SLOT_W-1:0] slot;
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
  logic [COLOR_W-1:0] entry_color;
  logic out_valid, out_ready;
  logic [COLOR_W-1:0] fate_color;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gravity_capture_fate_predictor #(.MAX_STEPS(STEP_LIMIT)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type), .slot(slot),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .entry_color(entry_color),
    .out_valid(out_valid), .out_ready(out_ready), .fate_color(fate_color),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // local copy of the table and registers
  logic signed [POS_W-1:0] tab_x [ATT];
  logic signed [POS_W-1:0] tab_y [ATT];
  logic signed [POS_W-1:0] tab_z [ATT];
  logic [COLOR_W-1:0]      tab_c [ATT];
  logic [31:0] cur_tick, cur_capture, cur_soft, cur_force;
  logic [DRAG_W-1:0] cur_drag;
  logic [COUNT_W-1:0] cur_count;

  logic [COLOR_W-1:0] fate_q [$];
  int mismatches = 0;
  longint cycles = 0;
  bit quiet;
  bit hold_go;
  int hold_cnt;
  int rx_wait;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) hold_cnt <= 0;
    else if (hold_go) hold_cnt <= 30000;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // result side: check against the oldest expected color
  always @(posedge clk) begin
    logic [COLOR_W-1:0] want;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (fate_q.size() == 0) begin
          $display("%0t: unexpected result fate_color=%h", $time, fate_color);
          mismatches++;
        end else begin
          want = fate_q.pop_front();
          if (fate_color !== want) begin
            $display("%0t: fate_color expected %h actual %h", $time, want, fate_color);
            mismatches++;
          end
        end
        rx_wait = quiet ? 0 : $urandom_range(0, 16);
      end
      if (hold_cnt > 0) out_ready <= 1'b0;
      else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  function automatic u64_t umag(input longint v);
    return v < 0 ? u64_t'(-v) : u64_t'(v);
  endfunction

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint scale_sh(input longint v, input u64_t k, input int sh);
    u64_t r;
    r = (umag(v) * k) >> sh;
    return v < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic u64_t root64(input u64_t x);
    u64_t r, b;
    r = 0;
    b = u64_t'(1) << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  // euler run from rest; returns the capturing color and how many steps ran
  function automatic logic [COLOR_W-1:0] predict_fate(input logic signed [POS_W-1:0] px,
      input logic signed [POS_W-1:0] py, input logic signed [POS_W-1:0] pz,
      output int steps_run);
    longint p [3];
    longint v [3];
    longint dc [3];
    u64_t v2, s4, d2, den, mg, f, len, m;
    longint q;
    int n;
    bit hit;
    logic [COLOR_W-1:0] res;
    n = (cur_count > ATT) ? ATT : cur_count;
    p[0] = px; p[1] = py; p[2] = pz;
    for (int k = 0; k < 3; k++) v[k] = 0;
    hit = 0;
    res = '0;
    steps_run = STEP_LIMIT;
    for (int st = 0; st < STEP_LIMIT && !hit; st++) begin
      v2 = 0;
      for (int k = 0; k < 3; k++) begin
        m = umag(v[k]);
        v2 += (m * m) >> DEF_FRAC_BITS;
      end
      for (int i = 0; i < n && !hit; i++) begin
        dc[0] = longint'(tab_x[i]) - p[0];
        dc[1] = longint'(tab_y[i]) - p[1];
        dc[2] = longint'(tab_z[i]) - p[2];
        s4 = 0;
        for (int k = 0; k < 3; k++) begin
          m = umag(dc[k]);
          s4 += (m * m) >> 2;
        end
        d2 = s4 >> (DEF_FRAC_BITS - 2);
        if (d2 < cur_capture && v2 < cur_force) begin
          hit = 1;
          res = tab_c[i];
          steps_run = st + 1;
        end else begin
          den = u64_t'(cur_soft) + d2;
          if (den == 0) mg = 64'hFFFF_FFFF;
          else mg = (u64_t'(cur_force) << DEF_FRAC_BITS) / den;
          if (mg > 64'hFFFF_FFFF) mg = 64'hFFFF_FFFF;
          f = (u64_t'(cur_tick) * mg) >> DEF_FRAC_BITS;
          if (f > 64'h7FFF_FFFF) f = 64'h7FFF_FFFF;
          len = 2 * root64(s4);
          if (len == 0) len = 1;
          // a zero axis adds nothing, so a zero direction leaves v alone
          for (int k = 0; k < 3; k++) begin
            q = longint'((umag(dc[k]) * f) / len);
            if (dc[k] < 0) q = -q;
            v[k] = sat32(v[k] + q);
          end
        end
      end
      if (!hit) begin
        for (int k = 0; k < 3; k++) begin
          v[k] = sat32(scale_sh(v[k], u64_t'(cur_drag), DRAG_FRAC));
          p[k] = sat32(p[k] + scale_sh(v[k], u64_t'(cur_tick), DEF_FRAC_BITS));
        end
      end
    end
    return res;
  endfunction

  task automatic send_request(input bit is_query, input logic [SLOT_W-1:0] s,
      input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
      input logic signed [POS_W-1:0] z, input logic [COLOR_W-1:0] c);
    int gap;
    int steps;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= is_query;
    slot <= s;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    entry_color <= c;
    do @(posedge clk); while (!in_ready);
    if (is_query) fate_q.insert(fate_q.size(), predict_fate(x, y, z, steps));
    else if (s < ATT) begin
      tab_x[s] = x; tab_y[s] = y; tab_z[s] = z; tab_c[s] = c;
    end
  endtask

  task automatic query_at(input logic signed [POS_W-1:0] x,
      input logic signed [POS_W-1:0] y, input logic signed [POS_W-1:0] z);
    send_request(1'b1, SLOT_W'($urandom_range(0, 7)), x, y, z,
                 COLOR_W'($urandom_range(0, 24'hFFFFFF)));
  endtask

  task automatic wait_idle;
    in_valid <= 1'b0;
    while (fate_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TICK:      cur_tick = val;
      REG_CAPTURE:   cur_capture = val;
      REG_DRAG:      cur_drag = val[DRAG_W-1:0];
      REG_SOFTENING: cur_soft = val;
      REG_FORCE:     cur_force = val;
      REG_COUNT:     cur_count = val[COUNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_table_load;
    send_request(1'b0, 3'd0, 32'sd0, 32'sd0, 32'sd0, 24'hFFFFFF);
    send_request(1'b0, 3'd1, PMAX, PMAX, PMAX, 24'h000001);
    send_request(1'b0, 3'd2, PMIN, PMIN, PMIN, 24'h800000);
    for (int i = 3; i < ATT; i++)
      send_request(1'b0, SLOT_W'(i), $urandom, $urandom, $urandom,
                   COLOR_W'($urandom_range(0, 24'hFFFFFF)));
    // no attractors in use yet, so these run out the step limit
    query_at(PMAX, PMIN, 32'sd0);
    query_at(PMIN, PMAX, PMAX);
    wait_idle();
  endtask

  task automatic test_capture_extremes;
    write_reg(REG_CAPTURE, 32'hFFFF_FFFF);
    write_reg(REG_FORCE, 32'hFFFF_FFFF);
    write_reg(REG_SOFTENING, 32'd1);
    write_reg(REG_COUNT, ATT);
    query_at(32'sd0, 32'sd0, 32'sd0);
    query_at(PMAX, PMAX, PMAX);
    query_at(PMIN, PMIN, PMIN);
    query_at(32'sd1, -32'sd1, 32'sd0);
    wait_idle();
  endtask

  task automatic test_zero_direction;
    // probe sits on the attractor and is never captured
    write_reg(REG_COUNT, 32'd1);
    write_reg(REG_CAPTURE, 32'd0);
    write_reg(REG_TICK, 32'd0);
    write_reg(REG_DRAG, 32'd0);
    query_at(32'sd0, 32'sd0, 32'sd0);
    wait_idle();
  endtask

  task automatic test_slow_capture;
    write_reg(REG_TICK, 32'h0001_0000);
    write_reg(REG_DRAG, 32'h0001_0000);
    write_reg(REG_CAPTURE, 32'h0001_0000);
    write_reg(REG_FORCE, 32'h0010_0000);
    query_at(32'sh0004_0000, 32'sd0, 32'sd0);
    wait_idle();
  endtask

  task automatic test_random_phases;
    int j, steps;
    logic signed [POS_W-1:0] x, y, z;
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      quiet <= (ph == 2);
      case (ph)
        0: begin
          write_reg(REG_TICK, 32'd0);
          write_reg(REG_DRAG, 32'd0);
          write_reg(REG_SOFTENING, 32'd1);
          write_reg(REG_FORCE, 32'd1);
          write_reg(REG_CAPTURE, 32'd1);
          write_reg(REG_COUNT, ATT);
        end
        1: begin
          write_reg(REG_TICK, 32'hFFFF_FFFF);
          write_reg(REG_DRAG, 32'h0001_0000);
          write_reg(REG_SOFTENING, 32'hFFFF_FFFF);
          write_reg(REG_FORCE, 32'hFFFF_FFFF);
          write_reg(REG_CAPTURE, 32'hFFFF_FFFF);
          write_reg(REG_COUNT, 32'd1);
        end
        default: begin
          write_reg(REG_TICK, $urandom >> $urandom_range(0, 31));
          write_reg(REG_DRAG, $urandom_range(0, 32'h0001_0000));
          write_reg(REG_SOFTENING, 1 + ($urandom >> $urandom_range(1, 31)));
          write_reg(REG_FORCE, 1 + ($urandom >> $urandom_range(1, 31)));
          write_reg(REG_CAPTURE, 1 + ($urandom >> $urandom_range(1, 31)));
          write_reg(REG_COUNT, $urandom_range(1, ATT));
        end
      endcase
      for (int it = 0; it < 16; it++) begin
        if ($urandom_range(0, 3) == 0) begin
          send_request(1'b0, SLOT_W'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                       COLOR_W'($urandom_range(0, 24'hFFFFFF)));
        end else begin
          j = $urandom_range(0, cur_count - 1);
          if ($urandom_range(0, 5) == 0) begin
            x = $urandom; y = $urandom; z = $urandom;
          end else begin
            x = tab_x[j] + ($signed($urandom) >>> $urandom_range(4, 31));
            y = tab_y[j] + ($signed($urandom) >>> $urandom_range(4, 31));
            z = tab_z[j] + ($signed($urandom) >>> $urandom_range(4, 31));
          end
          // keep the run short: fall back to sitting on an attractor
          void'(predict_fate(x, y, z, steps));
          if (steps > STEP_GUARD) begin
            x = tab_x[j]; y = tab_y[j]; z = tab_z[j];
          end
          query_at(x, y, z);
        end
      end
    end
    wait_idle();
    quiet <= 1'b0;
  endtask

  task automatic test_backpressure;
    int j;
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    for (int i = 0; i < 6; i++) begin
      j = $urandom_range(0, cur_count - 1);
      query_at(tab_x[j], tab_y[j], tab_z[j]);
    end
    wait_idle();
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= 1'b0;
    slot <= '0;
    pos_x <= '0;
    pos_y <= '0;
    pos_z <= '0;
    entry_color <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_TICK;
    cfg_data <= '0;
    quiet <= 1'b0;
    hold_go <= 1'b0;
    cur_tick = 32'd65536;
    cur_capture = 32'd0;
    cur_drag = 17'd65536;
    cur_soft = 32'd655;
    cur_force = 32'd66;
    cur_count = '0;
    for (int i = 0; i < ATT; i++) begin
      tab_x[i] = '0; tab_y[i] = '0; tab_z[i] = '0; tab_c[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_table_load();
    test_capture_extremes();
    test_zero_direction();
    test_slow_capture();
    test_random_phases();
    test_backpressure();

    wait_idle();
    repeat (50) @(posedge clk);
    if (fate_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* gravity_capture_fate_predictor.f */
+incdir+rtl
rtl/gcfp_pkg.sv
rtl/gcfp_unit.sv
rtl/gcfp_dp.sv
rtl/gcfp_ctrl.sv
rtl/gravity_capture_fate_predictor.sv
rtl/gcfp_checker.sv
bench/tb_gravity_capture_fate_predictor.sv
